FILE: rtl/crc8_frame_receiver_assert.svh
// assertion macros for the crc8 frame receiver
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CRC8_FRAME_RECEIVER_ASSERT_SVH
`define CRC8_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CRC8FR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crc8 frame receiver: implication check failed");

// next-cycle implication, disabled during reset
`define CRC8FR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crc8 frame receiver: next-cycle check failed");

`endif

FILE: rtl/crc8fr_pkg.sv
// types, constants and the crc8 byte fold for the crc8 frame receiver
// no dependencies
`timescale 1ns / 1ps

package crc8fr_pkg;

    localparam int MAX_DATA    = 127;
    localparam int STORE_DEPTH = 128;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int LEN_LIMIT   = (MAX_DATA < STORE_DEPTH - 1) ? MAX_DATA : STORE_DEPTH - 1;

    localparam logic [7:0]  SYNC_BYTE     = 8'h1B;
    localparam logic [7:0]  TYPE_BYTE     = 8'h40;
    localparam logic [7:0]  FIRST_CMD     = 8'h80;
    localparam logic [15:0] TIMEOUT_RESET = 16'd15;
    localparam logic [7:0]  POLY_RESET    = 8'h07;
    localparam logic [7:0]  INIT_RESET    = 8'h00;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_SYNC = 3'd0,
        PH_TYPE = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_HELD = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HELD    = 3'd1,
        ST_CLOSED  = 3'd2,
        ST_GOOD    = 3'd3,
        ST_CRC     = 3'd4,
        ST_TIMEOUT = 3'd5,
        ST_READ    = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        FN_BYTE    = 2'd0,
        FN_TICK    = 2'd1,
        FN_RELEASE = 2'd2,
        FN_READ    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_POLY    = 2'd2,
        CFG_INIT    = 2'd3
    } t_cfg_index;

    // msb-first crc8 update over one byte
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/crc8fr_ram.sv
// generic simple dual-port ram, registered read with read enable
// no dependencies
`timescale 1ns / 1ps

module crc8fr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/crc8_frame_receiver.sv
// top level of the crc8 frame receiver: deframer state, crc check, result pipeline
// depends on crc8fr_pkg, crc8fr_ram and crc8_frame_receiver_assert.svh
`timescale 1ns / 1ps

// crc8 frame receiver. each input transaction carries one function: a received byte,
// an idle tick, a release of the held frame, or a read of a held data byte. every
// input transaction yields exactly one result transaction. the block takes one
// transaction per clock cycle unless the result side stalls; the result is registered
// in stage one, beside the store's registered read port, then in the output register.
// frames are sync 0x1b, type 0x40, command >= 0x80, length <= MAX_DATA, the data and
// a crc8 byte; the crc (msb first, polynomial and start value from the configuration
// port) runs over the whole frame and must end at zero. a good frame is held until
// released; bytes arriving meanwhile are refused. the data store needs no clearing
// after reset since only bytes of the held frame are ever read. the user must write
// configuration only while no transaction is in flight; the block does not enforce it.
module crc8_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [0] frame_ready, [8:1] cmd_code, [15:9] data_len,
                                     // [23:16] read_byte
    output logic [2:0]  o_m_tuser    // [2:0] status
);
    import crc8fr_pkg::*;

    // configuration registers
    logic        r_cfg_enable;
    logic [15:0] r_cfg_timeout;
    logic [7:0]  r_cfg_poly;
    logic [7:0]  r_cfg_init;

    // deframer state
    t_phase       r_phase, n_phase;
    logic [6:0]   r_data_count, n_data_count;
    logic [6:0]   r_frame_len, n_frame_len;
    logic [7:0]   r_frame_cmd, n_frame_cmd;
    logic [7:0]   r_crc, n_crc;
    logic [15:0]  r_idle, n_idle;

    // first result stage (everything but the store read data)
    logic         r_p_valid;
    t_status      r_p_status, n_status;
    logic         r_p_ready;
    logic [7:0]   r_p_cmd;
    logic [6:0]   r_p_len;
    logic         r_p_rd_sel, n_rd_sel;

    // output register
    logic         r_o_valid;
    logic [2:0]   r_o_status;
    logic         r_o_ready;
    logic [7:0]   r_o_cmd;
    logic [6:0]   r_o_len;
    logic [7:0]   r_o_byte;

    // input fields
    t_func        in_func;
    logic [7:0]   in_byte;
    logic [6:0]   in_index;

    logic         accept;
    logic         out_adv;
    logic         store_we;
    logic [7:0]   store_rdata;
    logic [7:0]   crc_cont;
    logic [7:0]   crc_restart;
    logic [15:0]  tick_count;
    logic         n_held;

    assign in_func  = t_func'(i_s_tuser);
    assign in_byte  = i_s_tdata[7:0];
    assign in_index = i_s_tdata[14:8];

    // output register frees when empty or taken; stage one moves on then
    assign out_adv    = !r_o_valid || i_m_tready;
    assign o_s_tready = !r_p_valid || out_adv;
    assign accept     = i_s_tvalid && o_s_tready;

    assign crc_cont    = crc8_fold(r_crc, in_byte, r_cfg_poly);
    assign crc_restart = crc8_fold(r_cfg_init, in_byte, r_cfg_poly);
    assign tick_count  = (r_idle != TICKS_MAX) ? r_idle + 16'd1 : r_idle;

    // next state and result of one transaction
    always_comb begin
        n_phase      = r_phase;
        n_data_count = r_data_count;
        n_frame_len  = r_frame_len;
        n_frame_cmd  = r_frame_cmd;
        n_crc        = r_crc;
        n_idle       = r_idle;
        n_status     = ST_OK;
        n_rd_sel     = 1'b0;
        store_we     = 1'b0;

        if (accept) begin
            if (!r_cfg_enable) begin
                n_phase  = PH_SYNC;
                n_status = ST_CLOSED;
            end else begin
                case (in_func)
                    FN_BYTE: begin
                        if (r_phase == PH_HELD) begin
                            n_status = ST_HELD;
                        end else begin
                            n_idle = '0;
                            case (r_phase)
                                PH_TYPE: begin
                                    if (in_byte == TYPE_BYTE) begin
                                        n_crc   = crc_cont;
                                        n_phase = PH_CMD;
                                    end else if (in_byte == SYNC_BYTE) begin
                                        n_crc = crc_restart;
                                    end else begin
                                        n_phase = PH_SYNC;
                                    end
                                end
                                PH_CMD: begin
                                    if (in_byte >= FIRST_CMD) begin
                                        n_frame_cmd = in_byte;
                                        n_crc       = crc_cont;
                                        n_phase     = PH_LEN;
                                    end else if (in_byte == SYNC_BYTE) begin
                                        // resync in place of a command
                                        n_crc   = crc_restart;
                                        n_phase = PH_TYPE;
                                    end else begin
                                        n_phase = PH_SYNC;
                                    end
                                end
                                PH_LEN: begin
                                    if (in_byte <= 8'(LEN_LIMIT)) begin
                                        n_frame_len  = in_byte[6:0];
                                        n_data_count = '0;
                                        n_crc        = crc_cont;
                                        n_phase      = PH_DATA;
                                    end else begin
                                        n_phase = PH_SYNC;
                                    end
                                end
                                PH_DATA: begin
                                    n_crc = crc_cont;
                                    if (r_data_count < r_frame_len) begin
                                        store_we     = 1'b1;
                                        n_data_count = r_data_count + 7'd1;
                                    end else if (crc_cont == 8'd0) begin
                                        n_phase  = PH_HELD;
                                        n_status = ST_GOOD;
                                    end else begin
                                        n_phase  = PH_SYNC;
                                        n_status = ST_CRC;
                                    end
                                end
                                default: begin
                                    if (in_byte == SYNC_BYTE) begin
                                        n_crc   = crc_restart;
                                        n_phase = PH_TYPE;
                                    end else begin
                                        n_phase = PH_SYNC;
                                    end
                                end
                            endcase
                        end
                    end
                    FN_TICK: begin
                        // ticks count only inside a frame
                        if (r_phase == PH_TYPE || r_phase == PH_CMD ||
                            r_phase == PH_LEN || r_phase == PH_DATA) begin
                            n_idle = tick_count;
                            if (tick_count >= r_cfg_timeout) begin
                                n_phase  = PH_SYNC;
                                n_status = ST_TIMEOUT;
                            end
                        end
                    end
                    FN_RELEASE: begin
                        if (r_phase == PH_HELD) begin
                            n_phase = PH_SYNC;
                        end
                    end
                    default: begin
                        n_status = ST_READ;
                        n_rd_sel = (r_phase == PH_HELD) && (in_index < r_frame_len);
                    end
                endcase
            end
        end

        // disabling the channel drops any frame at once
        if (i_cfg_we && i_cfg_index == CFG_ENABLE && !i_cfg_data[0]) begin
            n_phase = PH_SYNC;
        end
    end

    assign n_held = (n_phase == PH_HELD);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable  <= 1'b0;
            r_cfg_timeout <= TIMEOUT_RESET;
            r_cfg_poly    <= POLY_RESET;
            r_cfg_init    <= INIT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ENABLE:  r_cfg_enable  <= i_cfg_data[0];
                CFG_TIMEOUT: r_cfg_timeout <= i_cfg_data;
                CFG_POLY:    r_cfg_poly    <= i_cfg_data[7:0];
                CFG_INIT:    r_cfg_init    <= i_cfg_data[7:0];
                default:     r_cfg_enable  <= r_cfg_enable;
            endcase
        end
    end

    // deframer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SYNC;
            r_data_count <= '0;
            r_frame_len  <= '0;
            r_frame_cmd  <= '0;
            r_crc        <= '0;
            r_idle       <= '0;
        end else begin
            r_phase      <= n_phase;
            r_data_count <= n_data_count;
            r_frame_len  <= n_frame_len;
            r_frame_cmd  <= n_frame_cmd;
            r_crc        <= n_crc;
            r_idle       <= n_idle;
        end
    end

    // result pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (out_adv) begin
                r_o_valid <= r_p_valid;
            end
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (out_adv) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_status <= n_status;
            r_p_ready  <= n_held;
            r_p_cmd    <= n_held ? n_frame_cmd : 8'd0;
            r_p_len    <= n_held ? n_frame_len : 7'd0;
            r_p_rd_sel <= n_rd_sel;
        end
        if (out_adv && r_p_valid) begin
            r_o_status <= r_p_status;
            r_o_ready  <= r_p_ready;
            r_o_cmd    <= r_p_cmd;
            r_o_len    <= r_p_len;
            r_o_byte   <= r_p_rd_sel ? store_rdata : 8'd0;
        end
    end

    // data store; read data holds while stage one is stalled
    crc8fr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_data_count[STORE_AW-1:0]),
        .i_wdata (in_byte),
        .i_re    (accept),
        .i_raddr (in_index[STORE_AW-1:0]),
        .o_rdata (store_rdata)
    );

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_byte, r_o_len, r_o_cmd, r_o_ready};
    assign o_m_tuser  = r_o_status;

`include "crc8_frame_receiver_assert.svh"

    // data never runs past the announced length
    `CRC8FR_ASSERT_IMP(a_count_in_len, r_phase == PH_DATA, r_data_count <= r_frame_len)
    // a closed channel always ends in wait for sync
    `CRC8FR_ASSERT_NXT(a_closed_idle, accept && !r_cfg_enable, r_phase == PH_SYNC)
    // a stalled first stage keeps its item
    `CRC8FR_ASSERT_NXT(a_stage_hold, r_p_valid && !out_adv, r_p_valid)
    // store read only selected for a held frame
    `CRC8FR_ASSERT_NXT(a_read_held, accept && r_phase != PH_HELD, !r_p_rd_sel)
    // store written only while collecting data
    `CRC8FR_ASSERT_IMP(a_write_data, store_we, r_phase == PH_DATA && accept)

endmodule

FILE: bench/crc8fr_checker.sv
// result checker for the crc8 frame receiver bench: a small package with the result type and a
// bitwise crc8 step, and a module that predicts each result and compares it with the block
// depends on crc8fr_pkg
`timescale 1ns / 1ps

package crc8fr_tb_pkg;

    import crc8fr_pkg::*;

    typedef struct packed {
        t_status    status;
        logic       frame_ready;
        logic [7:0] cmd_code;
        logic [6:0] data_len;
        logic [7:0] read_byte;
    } t_rx_result;

    // msb-first crc8, one message bit at a time
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[7] ^ b[k];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ poly;
            end
        end
        return r;
    endfunction

endpackage

module crc8fr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] func
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [0] frame_ready, [8:1] cmd_code, [15:9] data_len,
                                     // [23:16] read_byte
    input  logic [2:0]  i_m_tuser,   // [2:0] status
    output int          o_mismatches,
    output int          o_pending,
    output int          o_results,
    output int          o_good_frames,
    output int          o_crc_errors,
    output int          o_timeouts
);

    import crc8fr_pkg::*;
    import crc8fr_tb_pkg::*;

    // register copies
    logic        cfg_enable;
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_poly;
    logic [7:0]  cfg_init;

    // deframer state
    t_phase      phase;
    logic [7:0]  data_count;
    logic [6:0]  frame_len;
    logic [7:0]  frame_cmd;
    logic [7:0]  crc_acc;
    logic [15:0] idle_ticks;
    logic [7:0]  held_data [0:STORE_DEPTH-1];

    t_rx_result  expected_q [$];
    t_rx_result  seen;
    t_rx_result  want;
    int          mismatches;
    int          results;
    int          good_frames;
    int          crc_errors;
    int          timeouts;

    function automatic t_status take_rx_byte(input logic [7:0] b);
        t_status st;
        st         = ST_OK;
        idle_ticks = '0;
        case (phase)
            PH_TYPE: begin
                if (b == TYPE_BYTE) begin
                    crc_acc = crc8_next(crc_acc, b, cfg_poly);
                    phase   = PH_CMD;
                end else if (b == SYNC_BYTE) begin
                    crc_acc = crc8_next(cfg_init, b, cfg_poly);
                end else begin
                    phase = PH_SYNC;
                end
            end
            PH_CMD: begin
                if (b >= FIRST_CMD) begin
                    frame_cmd = b;
                    crc_acc   = crc8_next(crc_acc, b, cfg_poly);
                    phase     = PH_LEN;
                end else if (b == SYNC_BYTE) begin
                    crc_acc = crc8_next(cfg_init, b, cfg_poly);
                    phase   = PH_TYPE;
                end else begin
                    phase = PH_SYNC;
                end
            end
            PH_LEN: begin
                if (int'(b) <= LEN_LIMIT) begin
                    frame_len  = b[6:0];
                    data_count = '0;
                    crc_acc    = crc8_next(crc_acc, b, cfg_poly);
                    phase      = PH_DATA;
                end else begin
                    phase = PH_SYNC;
                end
            end
            PH_DATA: begin
                crc_acc = crc8_next(crc_acc, b, cfg_poly);
                if (data_count < {1'b0, frame_len}) begin
                    held_data[data_count[6:0]] = b;
                    data_count = data_count + 8'd1;
                end else if (crc_acc == 8'h00) begin
                    phase = PH_HELD;
                    st    = ST_GOOD;
                end else begin
                    phase = PH_SYNC;
                    st    = ST_CRC;
                end
            end
            default: begin
                if (b == SYNC_BYTE) begin
                    crc_acc = crc8_next(cfg_init, b, cfg_poly);
                    phase   = PH_TYPE;
                end else begin
                    phase = PH_SYNC;
                end
            end
        endcase
        return st;
    endfunction

    function automatic t_rx_result advance_deframer(input t_func fn, input logic [7:0] b,
                                                    input logic [6:0] idx);
        t_rx_result r;
        logic       held;
        r.status    = ST_OK;
        r.read_byte = 8'h00;
        if (!cfg_enable) begin
            phase    = PH_SYNC;
            r.status = ST_CLOSED;
        end else begin
            case (fn)
                FN_BYTE: begin
                    if (phase == PH_HELD) begin
                        r.status = ST_HELD;
                    end else begin
                        r.status = take_rx_byte(b);
                    end
                end
                FN_TICK: begin
                    if (phase == PH_TYPE || phase == PH_CMD || phase == PH_LEN
                            || phase == PH_DATA) begin
                        if (idle_ticks != TICKS_MAX) begin
                            idle_ticks = idle_ticks + 16'd1;
                        end
                        if (idle_ticks >= cfg_timeout) begin
                            phase    = PH_SYNC;
                            r.status = ST_TIMEOUT;
                        end
                    end
                end
                FN_RELEASE: begin
                    if (phase == PH_HELD) begin
                        phase = PH_SYNC;
                    end
                end
                default: begin
                    r.status = ST_READ;
                    if (phase == PH_HELD && idx < frame_len) begin
                        r.read_byte = held_data[idx];
                    end
                end
            endcase
        end
        held          = (phase == PH_HELD);
        r.frame_ready = held;
        r.cmd_code    = held ? frame_cmd : 8'h00;
        r.data_len    = held ? frame_len : 7'd0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_enable  = 1'b0;
            cfg_timeout = TIMEOUT_RESET;
            cfg_poly    = POLY_RESET;
            cfg_init    = INIT_RESET;
            phase       = PH_SYNC;
            data_count  = '0;
            frame_len   = '0;
            frame_cmd   = '0;
            crc_acc     = '0;
            idle_ticks  = '0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                held_data[i] = 8'h00;
            end
            expected_q.delete();
            mismatches  = 0;
            results     = 0;
            good_frames = 0;
            crc_errors  = 0;
            timeouts    = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_ENABLE: begin
                        cfg_enable = i_cfg_data[0];
                        if (!cfg_enable) begin
                            phase = PH_SYNC;
                        end
                    end
                    CFG_TIMEOUT: cfg_timeout = i_cfg_data;
                    CFG_POLY:    cfg_poly    = i_cfg_data[7:0];
                    default:     cfg_init    = i_cfg_data[7:0];
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_q.push_back(advance_deframer(t_func'(i_s_tuser), i_s_tdata[7:0],
                                                      i_s_tdata[14:8]));
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.status      = t_status'(i_m_tuser);
                seen.frame_ready = i_m_tdata[0];
                seen.cmd_code    = i_m_tdata[8:1];
                seen.data_len    = i_m_tdata[15:9];
                seen.read_byte   = i_m_tdata[23:16];
                results++;
                if (expected_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result %0d with nothing expected: status %0d ready %0b",
                                 results, seen.status, seen.frame_ready);
                    end
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    if (seen !== want) begin
                        if (mismatches < 10) begin
                            $display("result %0d mismatch: expected st %0d rdy %0b cmd %02h",
                                     results, want.status, want.frame_ready, want.cmd_code,
                                     " len %0d byte %02h", want.data_len, want.read_byte);
                            $display("    got st %0d rdy %0b cmd %02h len %0d byte %02h",
                                     seen.status, seen.frame_ready, seen.cmd_code,
                                     seen.data_len, seen.read_byte);
                        end
                        mismatches++;
                    end
                    if (want.status == ST_GOOD)    good_frames++;
                    if (want.status == ST_CRC)     crc_errors++;
                    if (want.status == ST_TIMEOUT) timeouts++;
                end
            end
        end
        o_mismatches  <= mismatches;
        o_pending     <= expected_q.size();
        o_results     <= results;
        o_good_frames <= good_frames;
        o_crc_errors  <= crc_errors;
        o_timeouts    <= timeouts;
    end

endmodule

FILE: bench/tb_crc8_frame_receiver.sv
// top of the crc8 frame receiver bench: clock, reset, register writes, input stimulus and verdict
// depends on crc8fr_pkg, crc8fr_tb_pkg and crc8fr_checker (bench/crc8fr_checker.sv)
`timescale 1ns / 1ps

module tb_crc8_frame_receiver;

    import crc8fr_pkg::*;
    import crc8fr_tb_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data  = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;
    logic [1:0]  s_tuser   = 2'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;

    int mismatches;
    int pending;
    int results;
    int good_frames;
    int crc_errors;
    int timeouts;

    // idle chance per cycle on each side, in percent
    int in_idle_pct  = 30;
    int out_idle_pct = 30;

    int items_sent     = 0;
    int settings_count = 0;

    // register values now in force, needed to build good crc bytes and tick gaps
    logic [15:0] cur_timeout = TIMEOUT_RESET;
    logic [7:0]  cur_poly    = POLY_RESET;
    logic [7:0]  cur_init    = INIT_RESET;

    always #5 clk = ~clk;

    crc8_frame_receiver i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    crc8fr_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results),
        .o_good_frames (good_frames),
        .o_crc_errors  (crc_errors),
        .o_timeouts    (timeouts)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // one input transaction: random idle cycles first, then hold until accepted.
    // called and returning at a rising edge, so every drive lands at an edge
    task automatic send_item(input t_func fn, input logic [7:0] b, input logic [6:0] idx);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, idx, b};
        s_tuser  <= fn;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // the unused field of each function carries random bits too
    task automatic send_byte(input logic [7:0] b);
        send_item(FN_BYTE, b, 7'($urandom_range(0, 127)));
    endtask

    task automatic send_tick();
        send_item(FN_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    endtask

    task automatic send_release();
        send_item(FN_RELEASE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input logic [6:0] idx);
        send_item(FN_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    // stop sending and wait until every expected result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // all four registers, written back to back while the block is idle
    task automatic apply_settings(input logic en, input logic [15:0] to,
                                  input logic [7:0] poly, input logic [7:0] init);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= {15'd0, en};
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= to;
        @(posedge clk);
        cfg_index <= CFG_POLY;
        cfg_data  <= {8'd0, poly};
        @(posedge clk);
        cfg_index <= CFG_INIT;
        cfg_data  <= {8'd0, init};
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_timeout = to;
        cur_poly    = poly;
        cur_init    = init;
        settings_count++;
    endtask

    // occasional run of idle ticks between two frame bytes; now and then a full
    // timeout's worth so the frame aborts, but only where the timeout is short
    task automatic gap_ticks();
        int n;
        if ($urandom_range(0, 99) < 10) begin
            if (cur_timeout <= 16'd64 && $urandom_range(0, 4) == 0) begin
                n = int'(cur_timeout);
            end else if (cur_timeout > 16'd4) begin
                n = $urandom_range(1, 3);
            end else begin
                n = int'(cur_timeout) - 1;
            end
            repeat (n) send_tick();
        end
    endtask

    // send one frame byte and fold it into the running crc
    task automatic frame_byte(input logic [7:0] b, inout logic [7:0] acc, input bit gaps);
        acc = crc8_next(acc, b, cur_poly);
        send_byte(b);
        if (gaps) begin
            gap_ticks();
        end
    endtask

    // a complete frame with random data; the crc byte equals the running crc so the
    // residue ends at zero, or is spoiled on request
    task automatic send_frame(input logic [7:0] cmd, input logic [6:0] len,
                              input bit bad_crc, input bit gaps);
        logic [7:0] acc;
        acc = cur_init;
        frame_byte(SYNC_BYTE, acc, gaps);
        frame_byte(TYPE_BYTE, acc, gaps);
        frame_byte(cmd, acc, gaps);
        frame_byte({1'b0, len}, acc, gaps);
        for (int k = 0; k < int'(len); k++) begin
            frame_byte(8'($urandom_range(0, 255)), acc, gaps);
        end
        send_byte(bad_crc ? acc ^ 8'($urandom_range(1, 255)) : acc);
    endtask

    // mostly short frames, some medium, a few near the store size
    function automatic logic [6:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return 7'($urandom_range(0, 6));
        end else if (r < 97) begin
            return 7'($urandom_range(7, 31));
        end
        return 7'($urandom_range(32, 127));
    endfunction

    // what a host does with a frame it may now hold: reads, a stray byte, a release
    task automatic after_frame(input logic [6:0] len);
        repeat ($urandom_range(0, 3)) begin
            if (len != 7'd0 && $urandom_range(0, 3) != 0) begin
                send_read(7'($urandom_range(0, int'(len) - 1)));
            end else begin
                send_read(7'($urandom_range(0, 127)));
            end
        end
        if ($urandom_range(0, 6) == 0) begin
            send_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 85) begin
            send_release();
        end
    endtask

    // frames that go wrong early: bad type, resync, bad command, bad length
    task automatic broken_frame();
        case ($urandom_range(0, 3))
            0: begin
                send_byte(SYNC_BYTE);
                send_byte(8'($urandom_range(0, 255)));
            end
            1: begin
                // sync arrives where the command is due, then a full frame follows
                send_byte(SYNC_BYTE);
                send_byte(TYPE_BYTE);
                send_frame(8'($urandom_range(128, 255)), pick_len(), 1'b0, 1'b1);
            end
            2: begin
                send_byte(SYNC_BYTE);
                send_byte(TYPE_BYTE);
                send_byte(8'($urandom_range(0, 127)));
            end
            default: begin
                send_byte(SYNC_BYTE);
                send_byte(TYPE_BYTE);
                send_byte(8'($urandom_range(128, 255)));
                send_byte(8'($urandom_range(128, 255)));
            end
        endcase
    endtask

    // one random transaction of any function, sync bytes favored
    task automatic noise_item();
        logic [7:0] b;
        b = ($urandom_range(0, 99) < 30) ? SYNC_BYTE : 8'($urandom_range(0, 255));
        send_item(t_func'($urandom_range(0, 3)), b, 7'($urandom_range(0, 127)));
    endtask

    task automatic random_part(input int n);
        int         stop;
        int         r;
        logic [6:0] len;
        stop = items_sent + n;
        while (items_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                len = pick_len();
                send_frame(8'($urandom_range(128, 255)), len,
                           $urandom_range(0, 99) < 15, 1'b1);
                after_frame(len);
            end else if (r < 75) begin
                broken_frame();
            end else begin
                repeat ($urandom_range(1, 3)) noise_item();
            end
        end
    endtask

    initial begin
        logic [7:0] acc;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // channel still closed after reset: every function is refused
        send_byte(SYNC_BYTE);
        send_tick();
        send_release();
        send_read(7'd0);

        // directed part, short timeout so the abort needs only two ticks
        apply_settings(1'b1, 16'd2, 8'h07, 8'h00);
        send_tick();
        send_release();
        send_read(7'h7F);

        // good frame, top command and one data byte of all ones
        acc = cur_init;
        frame_byte(SYNC_BYTE, acc, 1'b0);
        frame_byte(TYPE_BYTE, acc, 1'b0);
        frame_byte(8'hFF, acc, 1'b0);
        frame_byte(8'h01, acc, 1'b0);
        frame_byte(8'hFF, acc, 1'b0);
        send_byte(acc);
        send_read(7'd0);
        send_byte(8'h00);        // refused while held
        send_release();

        // empty frame with a spoiled crc byte
        acc = cur_init;
        frame_byte(SYNC_BYTE, acc, 1'b0);
        frame_byte(TYPE_BYTE, acc, 1'b0);
        frame_byte(FIRST_CMD, acc, 1'b0);
        frame_byte(8'h00, acc, 1'b0);
        send_byte(acc ^ 8'h01);

        // resync at type and at command, then a command below the range
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(TYPE_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(TYPE_BYTE);
        send_byte(8'h7F);

        // length one past the limit
        send_byte(SYNC_BYTE);
        send_byte(TYPE_BYTE);
        send_byte(FIRST_CMD);
        send_byte(8'h80);

        // idle gap in mid-frame
        send_byte(SYNC_BYTE);
        send_byte(TYPE_BYTE);
        send_tick();
        send_tick();

        // largest frame, read at the last entry and one past it
        send_frame(8'($urandom_range(128, 255)), 7'd127, 1'b0, 1'b0);
        send_read(7'd126);
        send_read(7'd127);
        send_release();
        random_part(100);

        // every tick in mid-frame aborts; all-ones polynomial and start value
        apply_settings(1'b1, 16'd1, 8'hFF, 8'hFF);
        random_part(100);
        // leave a good frame held so that closing the channel drops it
        send_tick();
        send_release();
        send_frame(8'($urandom_range(128, 255)), pick_len(), 1'b0, 1'b0);

        // closed channel
        apply_settings(1'b0, 16'd1, 8'hFF, 8'hFF);
        repeat (20) noise_item();

        // longest timeout, zero polynomial and start value, no idling on either side
        apply_settings(1'b1, TICKS_MAX, 8'h00, 8'h00);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        send_byte(SYNC_BYTE);
        send_byte(TYPE_BYTE);
        repeat (20) send_tick();  // far below the timeout, the frame stays open
        random_part(100);

        // random polynomial and start value, idling again
        in_idle_pct  = 30;
        out_idle_pct = 30;
        apply_settings(1'b1, 16'd40, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_part(100);

        // drain: every result back, then a few more cycles for anything stray
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("sent %0d transactions under %0d register settings, %0d results checked",
                 items_sent, settings_count, results);
        $display("seen %0d good frames, %0d crc errors, %0d timeout aborts, %0d mismatches",
                 good_frames, crc_errors, timeouts, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("** crc8_frame_receiver: PASSED **");
        end else begin
            $display("** crc8_frame_receiver: FAILED **");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("** crc8_frame_receiver: FAILED **");
        $finish;
    end

endmodule
